[rtl/clint_pkg.sv]
// Shared types and constants of the core-local interruptor.
package clint_pkg;

  // Request operations
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  // Register window offsets
  localparam logic [63:0] OFF_CMP_START = 64'h0000_0000_0000_4000;
  localparam logic [63:0] OFF_TIME_LO   = 64'h0000_0000_0000_BFF8;
  localparam logic [63:0] OFF_TIME_HI   = 64'h0000_0000_0000_BFFC;
  localparam logic [63:0] LOW32_MASK    = 64'h0000_0000_FFFF_FFFF;

  // Reset value of the window base address
  localparam logic [63:0] WINDOW_BASE_RESET = 64'h0000_0000_0200_0000;

  // Width of the pending vectors and of a hart number taken from an offset
  localparam int PEND_W    = 4;
  localparam int HART_NUM_W = 12;

endpackage

[rtl/core_local_timer_interruptor_core.sv]
// Core-local interruptor: software flags, timer compares and the time counter.
// A request is held in the input register once accepted; its result is valid once it moves into the result register.
// Throughput: one request per cycle while the output is drained; the input register and the result register
// each advance whenever the stage after them is empty or is being drained.
// Reset (rst, synchronous, active high) clears flags, compares, time counter,
// valid bits, and restores the window base to 0x2000000.
module core_local_timer_interruptor_core
  import clint_pkg::*;
#(
  parameter int HART_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [63:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [63:0] address,
  input  logic [63:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] read_data,
  output logic [3:0]  soft_pending,
  output logic [3:0]  timer_pending,
  output logic [63:0] time_now
);

  localparam int HART_W = (HART_COUNT > 1) ? $clog2(HART_COUNT) : 1;
  localparam int VIS    = (HART_COUNT < PEND_W) ? HART_COUNT : PEND_W;
  localparam logic [HART_NUM_W-1:0] HART_LIMIT = HART_NUM_W'(HART_COUNT);

  // Architectural state
  logic [63:0]           window_base;
  logic [HART_COUNT-1:0] soft_flags;
  logic [63:0]           compare_values [HART_COUNT];
  logic [63:0]           time_count;

  // Input register
  logic        req_valid;
  opcode_t     req_op;
  logic [63:0] req_off;
  logic [63:0] req_data;

  logic advance;
  logic capture;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !req_valid || advance;
  assign capture  = in_valid && in_ready;

  // Hold the window base; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= WINDOW_BASE_RESET;
    end else if (cfg_write_en) begin
      window_base <= cfg_write_data;
    end
  end

  // Capture the request and reduce the address to a window offset
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      req_op   <= opcode_t'(opcode);
      req_off  <= address - window_base;
      req_data <= write_data;
    end
  end

  // Decode the offset
  logic                  in_flag_region;
  logic                  in_cmp_region;
  logic [15:0]           cmp_rel;
  logic [HART_NUM_W-1:0] flag_hart_num;
  logic [HART_NUM_W-1:0] cmp_hart_num;
  logic                  flag_hit;
  logic                  cmp_hit;
  logic [HART_W-1:0]     flag_hart;
  logic [HART_W-1:0]     cmp_hart;
  logic                  time_lo_hit;
  logic                  time_hi_hit;

  always_comb begin
    in_flag_region = (req_off < OFF_CMP_START);
    in_cmp_region  = !in_flag_region && (req_off < OFF_TIME_LO);
    cmp_rel        = req_off[15:0] - OFF_CMP_START[15:0];
    flag_hart_num  = req_off[13:2];
    cmp_hart_num   = cmp_rel[14:3];
    flag_hit       = in_flag_region && (flag_hart_num < HART_LIMIT);
    cmp_hit        = in_cmp_region && (cmp_hart_num < HART_LIMIT);
    // Drop to hart zero when out of range so the index stays inside the array
    flag_hart      = flag_hit ? flag_hart_num[HART_W-1:0] : '0;
    cmp_hart       = cmp_hit ? cmp_hart_num[HART_W-1:0] : '0;
    time_lo_hit    = (req_off == OFF_TIME_LO);
    time_hi_hit    = (req_off == OFF_TIME_HI);
  end

  // Work out the next state and the read data
  logic                  do_step;
  logic [HART_COUNT-1:0] soft_flags_next;
  logic [63:0]           compare_next [HART_COUNT];
  logic [63:0]           time_count_next;
  logic [63:0]           read_data_next;
  logic [3:0]            soft_pending_next;
  logic [3:0]            timer_pending_next;

  assign do_step = req_valid && advance;

  always_comb begin
    soft_flags_next = soft_flags;
    compare_next    = compare_values;
    time_count_next = time_count;
    read_data_next  = '0;
    unique case (req_op)
      OP_READ: begin
        if (flag_hit) begin
          read_data_next = {63'd0, soft_flags[flag_hart]};
        end else if (cmp_hit) begin
          read_data_next = compare_values[cmp_hart];
        end else if (time_lo_hit) begin
          read_data_next = time_count & LOW32_MASK;
        end else if (time_hi_hit) begin
          read_data_next = {32'd0, time_count[63:32]};
        end
      end
      OP_WRITE: begin
        if (flag_hit) begin
          soft_flags_next[flag_hart] = req_data[0];
        end else if (cmp_hit) begin
          compare_next[cmp_hart] = req_data;
        end
      end
      OP_TICK: begin
        time_count_next = time_count + 64'd1;
      end
      default: begin
      end
    endcase
  end

  // Pending vectors of the harts that fit the 4-bit outputs
  always_comb begin
    soft_pending_next  = '0;
    timer_pending_next = '0;
    for (int i = 0; i < VIS; i++) begin
      soft_pending_next[i]  = soft_flags_next[i];
      timer_pending_next[i] = (time_count_next >= compare_next[i]);
    end
  end

  // Commit the state when the request moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      soft_flags <= '0;
      time_count <= '0;
      for (int i = 0; i < HART_COUNT; i++) begin
        compare_values[i] <= '0;
      end
    end else if (do_step) begin
      soft_flags     <= soft_flags_next;
      time_count     <= time_count_next;
      compare_values <= compare_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      read_data     <= read_data_next;
      soft_pending  <= soft_pending_next;
      timer_pending <= timer_pending_next;
      time_now      <= time_count_next;
    end
  end

endmodule

[verif/tb_core_local_timer_interruptor_core.sv]
// Testbench for the core-local interruptor: directed map checks, random traffic, base moves.
module tb_core_local_timer_interruptor_core;
  import clint_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HARTS       = 4;
  localparam int IDLE_MAX    = 11;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCS = 4;

  typedef struct packed {
    logic [63:0] rdata;
    logic [3:0]  swi;
    logic [3:0]  timer;
    logic [63:0] tnow;
  } clint_reply_t;

  // Block ports, the inputs all known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [63:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_NOP;
  logic [63:0] address = '0;
  logic [63:0] write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] read_data;
  logic [3:0]  soft_pending;
  logic [3:0]  timer_pending;
  logic [63:0] time_now;

  // Shadow copy of the interruptor state
  logic [63:0]      base_m;
  logic [HARTS-1:0] soft_m;
  logic [63:0]      cmp_m [HARTS];
  logic [63:0]      time_m;

  clint_reply_t expected_replies[$];

  int idle_max = IDLE_MAX;
  int error_count = 0;
  int quiet_cycles = 0;
  int n_reads = 0, n_writes = 0, n_ticks = 0, n_nops = 0, n_replies = 0, n_bases = 0;

  core_local_timer_interruptor_core #(.HART_COUNT(HARTS)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .address       (address),
    .write_data    (write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .soft_pending  (soft_pending),
    .timer_pending (timer_pending),
    .time_now      (time_now)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the shadow state and return the reply it should give
  function automatic clint_reply_t predict_access(opcode_t op, logic [63:0] addr,
                                                  logic [63:0] wdata);
    logic [63:0] off;
    logic [63:0] hart;
    clint_reply_t r;
    off = addr - base_m;
    r = '0;
    case (op)
      OP_READ: begin
        if (off < OFF_CMP_START) begin
          hart = off >> 2;
          if (hart < HARTS) r.rdata = {63'd0, soft_m[hart[1:0]]};
        end else if (off < OFF_TIME_LO) begin
          hart = (off - OFF_CMP_START) >> 3;
          if (hart < HARTS) r.rdata = cmp_m[hart[1:0]];
        end else if (off == OFF_TIME_LO) begin
          r.rdata = time_m & LOW32_MASK;
        end else if (off == OFF_TIME_HI) begin
          r.rdata = time_m >> 32;
        end
      end
      OP_WRITE: begin
        // the time counter and unmapped offsets drop writes
        if (off < OFF_CMP_START) begin
          hart = off >> 2;
          if (hart < HARTS) soft_m[hart[1:0]] = wdata[0];
        end else if (off < OFF_TIME_LO) begin
          hart = (off - OFF_CMP_START) >> 3;
          if (hart < HARTS) cmp_m[hart[1:0]] = wdata;
        end
      end
      OP_TICK: time_m = time_m + 64'd1;
      default: ;
    endcase
    for (int h = 0; h < HARTS; h++) begin
      r.swi[h]   = soft_m[h];
      r.timer[h] = (time_m >= cmp_m[h]);
    end
    r.tnow = time_m;
    return r;
  endfunction

  // Predict on every accepted request, check every accepted reply
  always @(posedge clk) begin : scoreboard
    clint_reply_t due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_replies++;
        if (expected_replies.size() == 0) begin
          $error("reply with no request outstanding");
          error_count++;
        end else begin
          due = expected_replies.pop_front();
          if (read_data !== due.rdata) begin
            $error("read_data: expected %h, got %h", due.rdata, read_data);
            error_count++;
          end
          if (soft_pending !== due.swi) begin
            $error("soft_pending: expected %h, got %h", due.swi, soft_pending);
            error_count++;
          end
          if (timer_pending !== due.timer) begin
            $error("timer_pending: expected %h, got %h", due.timer, timer_pending);
            error_count++;
          end
          if (time_now !== due.tnow) begin
            $error("time_now: expected %h, got %h", due.tnow, time_now);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (opcode_t'(opcode))
          OP_READ:  n_reads++;
          OP_WRITE: n_writes++;
          OP_TICK:  n_ticks++;
          default:  n_nops++;
        endcase
        expected_replies.insert(expected_replies.size(),
                                predict_access(opcode_t'(opcode), address, write_data));
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Drain side: stall a random number of cycles before taking each reply
  initial begin : reply_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = (idle_max == 0) ? 0 : $urandom_range(idle_max, 0);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(opcode_t op, logic [63:0] addr, logic [63:0] wdata);
    int gap;
    gap = (idle_max == 0) ? 0 : $urandom_range(idle_max, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    address    <= addr;
    write_data <= wdata;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold requests until every reply is back, then let the pipeline empty
  task automatic settle_idle();
    in_valid <= 1'b0;
    // let the last accepted request land in the queue first
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCS) @(posedge clk);
  endtask

  task automatic write_window_base(logic [63:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    base_m = value;
    n_bases++;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic opcode_t pick_opcode();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 38) return OP_READ;
    if (sel < 70) return OP_WRITE;
    if (sel < 95) return OP_TICK;
    return OP_NOP;
  endfunction

  // Mostly mapped offsets, some edges of the map, some anywhere
  function automatic logic [63:0] pick_offset();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 35) return 64'(($urandom_range(5, 0) << 2) | $urandom_range(3, 0));
    if (sel < 70) return OFF_CMP_START + 64'(($urandom_range(5, 0) << 3) + $urandom_range(7, 0));
    if (sel < 80) return $urandom_range(1, 0) ? OFF_TIME_LO : OFF_TIME_HI;
    if (sel < 88) begin
      case ($urandom_range(7, 0))
        0: return OFF_CMP_START - 64'd1;
        1: return OFF_CMP_START - 64'd4;
        2: return OFF_TIME_LO - 64'd1;
        3: return OFF_TIME_LO + 64'd1;
        4: return OFF_TIME_HI + 64'd4;
        5: return 64'h0000_0000_0001_0000;
        6: return '1;
        default: return 64'h0000_0000_0000_FFFF;
      endcase
    end
    if (sel < 94) return 64'($urandom_range(16'hFFFF, 0));
    return {$urandom, $urandom};
  endfunction

  // Compare values near the counter so the timer vector keeps changing
  function automatic logic [63:0] pick_data();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    if (sel < 4) return {$urandom, $urandom};
    if (sel < 7) return time_m + 64'($urandom_range(12, 0)) - 64'd4;
    if (sel == 7) return '0;
    if (sel == 8) return '1;
    return 64'($urandom_range(1, 0));
  endfunction

  task automatic run_traffic(int count);
    opcode_t op;
    logic [63:0] off;
    logic [63:0] wdata;
    for (int k = 0; k < count; k++) begin
      op    = pick_opcode();
      off   = pick_offset();
      wdata = pick_data();
      send_request(op, base_m + off, wdata);
      // every so often wait for the pipeline to run dry
      if (k % 97 == 96) settle_idle();
    end
  endtask

  // Walk the map at the reset base: flags, compares, counter halves, holes
  task automatic test_register_map();
    logic [63:0] b;
    b = base_m;
    send_request(OP_READ,  b,                    '0);
    send_request(OP_READ,  b + OFF_CMP_START,    '0);
    send_request(OP_READ,  b + OFF_TIME_LO,      '1);
    send_request(OP_WRITE, b,                    '1);
    send_request(OP_WRITE, b + 64'hC,            64'hFFFF_FFFF_FFFF_FFFE);
    send_request(OP_WRITE, b + 64'hB,            64'd1);
    send_request(OP_WRITE, b + 64'h10,           64'd1);
    send_request(OP_READ,  b + 64'h9,            '0);
    send_request(OP_READ,  b + 64'h3FFC,         '0);
    send_request(OP_WRITE, b + 64'h400F,         '1);
    send_request(OP_READ,  b + 64'h4008,         '0);
    send_request(OP_WRITE, b + 64'h4020,         64'd5);
    send_request(OP_READ,  b + 64'h4020,         '0);
    send_request(OP_WRITE, b + OFF_CMP_START,    64'd3);
    send_request(OP_WRITE, b + OFF_TIME_LO,      '1);
    send_request(OP_WRITE, b + OFF_TIME_HI,      '1);
    repeat (3) send_request(OP_TICK, '1, '1);
    send_request(OP_READ,  b + OFF_TIME_LO,      '0);
    send_request(OP_READ,  b + OFF_TIME_HI,      '0);
    send_request(OP_READ,  b + OFF_TIME_LO - 1,  '0);
    send_request(OP_WRITE, b + 64'hC000,         '1);
    send_request(OP_READ,  b + 64'hC000,         '0);
    send_request(OP_READ,  b - 64'd1,            '0);
    send_request(OP_NOP,   '1,                   '1);
    send_request(OP_WRITE, b,                    '0);
  endtask

  task automatic test_back_to_back();
    idle_max = 0;
    run_traffic(200);
    idle_max = IDLE_MAX;
  endtask

  task automatic test_random_idle();
    idle_max = IDLE_MAX;
    run_traffic(400);
  endtask

  // Move the window to both ends of the address space and somewhere random, then back to the reset base
  task automatic test_window_base();
    logic [63:0] bases [3];
    bases[0] = '0;
    bases[1] = '1;
    bases[2] = {$urandom, $urandom};
    foreach (bases[i]) begin
      settle_idle();
      write_window_base(bases[i]);
      run_traffic(170);
    end
    settle_idle();
    write_window_base(WINDOW_BASE_RESET);
    run_traffic(120);
  endtask

  initial begin
    base_m = WINDOW_BASE_RESET;
    soft_m = '0;
    time_m = '0;
    foreach (cmp_m[i]) cmp_m[i] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_map();
    test_back_to_back();
    test_random_idle();
    test_window_base();

    settle_idle();
    repeat (8) @(posedge clk);

    $display("summary: %0d reads, %0d writes, %0d ticks, %0d no-ops; %0d replies checked",
             n_reads, n_writes, n_ticks, n_nops, n_replies);
    $display("summary: window base moved %0d times (zero, all ones, random, reset); time %0d",
             n_bases, time_m);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
